// ===== src/vmes_pkg.sv =====
// Shared types and constants for the von Mises equivalent stress unit.
`timescale 1ns / 1ps

package vmes_pkg;

   // Problem dimension register.
   localparam int DIM_WIDTH = 2;
   typedef logic [DIM_WIDTH-1:0] dim_type;

   // Code that selects the full 3D formula; every other code selects the plane formula.
   localparam dim_type DIM_3D = 2'd3;

   // Register file geometry.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register index, taken from the word address bit.
   localparam logic CSR_DIMENSION_INDEX = 1'b0;

endpackage

// ===== src/von_mises_equivalent_stress_unit.sv =====
// Top level of the von Mises equivalent stress unit: register, pipeline and output skid.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  six stress components, signed
//   rsp       out        rsp_valid / rsp_ready  equivalent_stress, unsigned
//   csr       in/out     APB write/read         dimension at byte address 0
//
// One item enters per cycle while req_ready is high. The pipeline has four
// front-end stages, one square-root stage per result bit, and the output
// register. Reset clears every valid bit and sets dimension to 3.
// A stalled output fills a one-entry skid buffer; req_ready then drops and the
// whole pipeline holds until the skid drains.
`timescale 1ns / 1ps

module von_mises_equivalent_stress_unit #(
   parameter int COMPONENT_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_normal_xx,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_normal_yy,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_normal_zz,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_shear_xy,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_shear_yz,
   input  logic signed [COMPONENT_WIDTH-1:0]      req_shear_xz,
   // Result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [COMPONENT_WIDTH:0]               rsp_equivalent_stress,
   // Register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [vmes_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [vmes_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [vmes_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   import vmes_pkg::*;

   localparam int RW = COMPONENT_WIDTH + 1;
   localparam int SW = 2 * COMPONENT_WIDTH + 2;

   dim_type       dimension_ff, dimension_in;
   logic          dim_write;
   logic          dim_select;

   logic          pipe_en;
   logic          sum_valid;
   logic [SW-1:0] sum_value;
   logic          res_valid;
   logic [RW-1:0] res_root;
   logic          load;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_data_ff, rsp_data_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [RW-1:0] skid_data_ff, skid_data_in;

   // Dimension register; the byte offset bits are ignored.
   assign dim_select   = (csr_paddr[2] == CSR_DIMENSION_INDEX);
   assign dim_write    = csr_psel && csr_penable && csr_pwrite && dim_select;
   assign dimension_in = dim_write ? csr_pwdata[DIM_WIDTH-1:0] : dimension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_3D;
      end else begin
         dimension_ff <= dimension_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = dim_select ? {{(CSR_DATA_WIDTH-DIM_WIDTH){1'b0}}, dimension_ff} : '0;

   // The pipeline advances whenever the skid buffer is empty.
   assign pipe_en   = !skid_valid_ff;
   assign req_ready = pipe_en;

   vmes_terms #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_terms (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (req_valid),
      .dimension (dimension_ff),
      .normal_xx (req_normal_xx),
      .normal_yy (req_normal_yy),
      .normal_zz (req_normal_zz),
      .shear_xy  (req_shear_xy),
      .shear_yz  (req_shear_yz),
      .shear_xz  (req_shear_xz),
      .out_valid (sum_valid),
      .out_sum   (sum_value)
   );

   vmes_isqrt #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .in_valid  (sum_valid),
      .in_value  (sum_value),
      .out_valid (res_valid),
      .out_root  (res_root)
   );

   assign load = pipe_en && res_valid;

   // Output register with a one-entry skid buffer behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (load) begin
            rsp_data_in = res_root;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff) begin
         if (load) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_root;
         end
      end else begin
         if (load) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_root;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_equivalent_stress = rsp_data_ff;

   // The skid buffer only holds an item behind a full output register.
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid buffer full while output register empty");

   // A result arriving at a blocked output must be parked, not dropped.
   a_park_blocked : assert property (@(posedge clock) disable iff (reset)
      (load && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("result lost at blocked output");

   // A taken output empties the skid buffer in the following cycle.
   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)
      else $error("skid buffer did not drain");

endmodule

// ===== src/vmes_terms.sv =====
// Four-stage front end: normal differences, squares, partial sums and the von Mises sum.
`timescale 1ns / 1ps

module vmes_terms #(
   parameter int COMPONENT_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  vmes_pkg::dim_type                   dimension,
   input  logic signed [COMPONENT_WIDTH-1:0]   normal_xx,
   input  logic signed [COMPONENT_WIDTH-1:0]   normal_yy,
   input  logic signed [COMPONENT_WIDTH-1:0]   normal_zz,
   input  logic signed [COMPONENT_WIDTH-1:0]   shear_xy,
   input  logic signed [COMPONENT_WIDTH-1:0]   shear_yz,
   input  logic signed [COMPONENT_WIDTH-1:0]   shear_xz,
   output logic                                out_valid,
   output logic [2*COMPONENT_WIDTH+1:0]        out_sum
);

   import vmes_pkg::*;

   localparam int CW  = COMPONENT_WIDTH;
   localparam int DW  = CW + 1;           // normal difference width
   localparam int SQW = 2 * CW;           // square of a difference
   localparam int SHW = 2 * CW - 1;       // square of a shear
   localparam int SSW = 2 * CW + 1;       // sum of three shear squares
   localparam int SW  = 2 * CW + 2;       // sum of three difference squares, and the total

   logic              plane;
   logic signed [CW-1:0] zz_use;
   logic signed [CW-1:0] yz_use;
   logic signed [CW-1:0] xz_use;
   logic signed [DW-1:0] xx_ext;
   logic signed [DW-1:0] yy_ext;
   logic signed [DW-1:0] zz_ext;

   logic [3:0]           valid_ff;
   logic [3:0]           valid_in;

   logic signed [DW-1:0] d1_ff, d1_in;
   logic signed [DW-1:0] d2_ff, d2_in;
   logic signed [DW-1:0] d3_ff, d3_in;
   logic signed [CW-1:0] xy_ff, xy_in;
   logic signed [CW-1:0] yz_ff, yz_in;
   logic signed [CW-1:0] xz_ff, xz_in;

   logic signed [2*DW-1:0] d1_prod, d2_prod, d3_prod;
   logic signed [2*CW-1:0] xy_prod, yz_prod, xz_prod;
   logic [SQW-1:0]         sq_d1_ff, sq_d1_in;
   logic [SQW-1:0]         sq_d2_ff, sq_d2_in;
   logic [SQW-1:0]         sq_d3_ff, sq_d3_in;
   logic [SHW-1:0]         sq_xy_ff, sq_xy_in;
   logic [SHW-1:0]         sq_yz_ff, sq_yz_in;
   logic [SHW-1:0]         sq_xz_ff, sq_xz_in;

   logic [SW-1:0]          normal_sum_ff, normal_sum_in;
   logic [SSW-1:0]         shear_sum_ff, shear_sum_in;

   logic [SW-1:0]          total_ff, total_in;

   // The plane formula equals the 3D formula with zz, yz and xz forced to zero.
   assign plane  = (dimension != DIM_3D);
   assign zz_use = plane ? '0 : normal_zz;
   assign yz_use = plane ? '0 : shear_yz;
   assign xz_use = plane ? '0 : shear_xz;

   assign xx_ext = {normal_xx[CW-1], normal_xx};
   assign yy_ext = {normal_yy[CW-1], normal_yy};
   assign zz_ext = {zz_use[CW-1], zz_use};

   // Stage A: normal stress differences.
   assign d1_in = xx_ext - yy_ext;
   assign d2_in = yy_ext - zz_ext;
   assign d3_in = zz_ext - xx_ext;
   assign xy_in = shear_xy;
   assign yz_in = yz_use;
   assign xz_in = xz_use;

   // Stage B: one square per term; all squares are non-negative and fit the kept width.
   assign d1_prod  = d1_ff * d1_ff;
   assign d2_prod  = d2_ff * d2_ff;
   assign d3_prod  = d3_ff * d3_ff;
   assign xy_prod  = xy_ff * xy_ff;
   assign yz_prod  = yz_ff * yz_ff;
   assign xz_prod  = xz_ff * xz_ff;
   assign sq_d1_in = d1_prod[SQW-1:0];
   assign sq_d2_in = d2_prod[SQW-1:0];
   assign sq_d3_in = d3_prod[SQW-1:0];
   assign sq_xy_in = xy_prod[SHW-1:0];
   assign sq_yz_in = yz_prod[SHW-1:0];
   assign sq_xz_in = xz_prod[SHW-1:0];

   // Stage C: partial sums of the normal and the shear squares.
   assign normal_sum_in = SW'(sq_d1_ff) + SW'(sq_d2_ff) + SW'(sq_d3_ff);
   assign shear_sum_in  = SSW'(sq_xy_ff) + SSW'(sq_yz_ff) + SSW'(sq_xz_ff);

   // Stage D: half the normal sum (always even) plus three times the shear sum.
   assign total_in = SW'(normal_sum_ff >> 1) + SW'(shear_sum_ff) + {shear_sum_ff, 1'b0};

   assign valid_in = {valid_ff[2:0], in_valid};

   // Valid bits travel with the data and freeze while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // Data registers of the four stages.
   always_ff @(posedge clock) begin
      if (enable) begin
         d1_ff         <= d1_in;
         d2_ff         <= d2_in;
         d3_ff         <= d3_in;
         xy_ff         <= xy_in;
         yz_ff         <= yz_in;
         xz_ff         <= xz_in;
         sq_d1_ff      <= sq_d1_in;
         sq_d2_ff      <= sq_d2_in;
         sq_d3_ff      <= sq_d3_in;
         sq_xy_ff      <= sq_xy_in;
         sq_yz_ff      <= sq_yz_in;
         sq_xz_ff      <= sq_xz_in;
         normal_sum_ff <= normal_sum_in;
         shear_sum_ff  <= shear_sum_in;
         total_ff      <= total_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_sum   = total_ff;

endmodule

// ===== src/vmes_isqrt_step.sv =====
// One registered digit of the pipelined integer square root.
`timescale 1ns / 1ps

module vmes_isqrt_step #(
   parameter int COMPONENT_WIDTH = 24,
   parameter int DIGIT           = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           valid_i,
   input  logic [2*COMPONENT_WIDTH+1:0]   rem_i,
   input  logic [COMPONENT_WIDTH:0]       root_i,
   output logic                           valid_o,
   output logic [2*COMPONENT_WIDTH+1:0]   rem_o,
   output logic [COMPONENT_WIDTH:0]       root_o
);

   localparam int RW = COMPONENT_WIDTH + 1;
   localparam int SW = 2 * COMPONENT_WIDTH + 2;

   logic [SW-1:0] trial;
   logic          take;
   logic          valid_ff, valid_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;

   // Setting this digit raises root^2 by (2*root + 2^d) * 2^d. The root holds
   // only bits above this digit, so the two parts never overlap.
   assign trial = ({{(SW-RW){1'b0}}, root_i} << (DIGIT + 1))
                | ({{(SW-1){1'b0}}, 1'b1} << (2 * DIGIT));
   assign take  = (trial <= rem_i);

   assign valid_in = valid_i;
   assign rem_in   = take ? (rem_i - trial) : rem_i;
   assign root_in  = take ? (root_i | (RW'(1) << DIGIT)) : root_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;

endmodule

// ===== src/vmes_isqrt.sv =====
// Pipelined floor square root: one stage per result bit, most significant first.
`timescale 1ns / 1ps

module vmes_isqrt #(
   parameter int COMPONENT_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic [2*COMPONENT_WIDTH+1:0]   in_value,
   output logic                           out_valid,
   output logic [COMPONENT_WIDTH:0]       out_root
);

   localparam int RW = COMPONENT_WIDTH + 1;
   localparam int SW = 2 * COMPONENT_WIDTH + 2;

   logic [RW:0]   valid_chain;
   logic [SW-1:0] rem_chain  [0:RW-1];
   logic [RW-1:0] root_chain [0:RW];

   assign valid_chain[0] = in_valid;
   assign rem_chain[0]   = in_value;
   assign root_chain[0]  = '0;

   // Stage k resolves result bit RW-1-k.
   for (genvar k = 0; k < RW; k++) begin : g_digit
      if (k < RW - 1) begin : g_mid
         vmes_isqrt_step #(
            .COMPONENT_WIDTH (COMPONENT_WIDTH),
            .DIGIT           (RW - 1 - k)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .enable  (enable),
            .valid_i (valid_chain[k]),
            .rem_i   (rem_chain[k]),
            .root_i  (root_chain[k]),
            .valid_o (valid_chain[k+1]),
            .rem_o   (rem_chain[k+1]),
            .root_o  (root_chain[k+1])
         );
      end else begin : g_last
         // The final remainder is not needed.
         vmes_isqrt_step #(
            .COMPONENT_WIDTH (COMPONENT_WIDTH),
            .DIGIT           (RW - 1 - k)
         ) u_step (
            .clock   (clock),
            .reset   (reset),
            .enable  (enable),
            .valid_i (valid_chain[k]),
            .rem_i   (rem_chain[k]),
            .root_i  (root_chain[k]),
            .valid_o (valid_chain[k+1]),
            .rem_o   (),
            .root_o  (root_chain[k+1])
         );
      end
   end

   assign out_valid = valid_chain[RW];
   assign out_root  = root_chain[RW];

   // A stalled pipeline neither drops nor creates items in any stage.
   a_frozen_valid : assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_chain[RW:1]))
      else $error("square root stages changed while stalled");

endmodule

// ===== test/vmes_stress_checker.sv =====
// Checker for the von Mises unit: tracks the dimension register, predicts and compares results.
`timescale 1ns / 1ps

module vmes_stress_checker #(
   parameter int COMPONENT_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_normal_xx,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_normal_yy,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_normal_zz,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_shear_xy,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_shear_yz,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_shear_xz,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [COMPONENT_WIDTH:0]              rsp_equivalent_stress,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [vmes_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [vmes_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   input  logic [vmes_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   input  logic                                  csr_pready,
   output int                                    fail_count,
   output int                                    outstanding_count
);

   import vmes_pkg::*;

   // Our own copy of the dimension register and the results still owed by the block.
   dim_type                   dimension_shadow = DIM_3D;
   logic [COMPONENT_WIDTH:0]  expected_stress_q[$];
   logic [COMPONENT_WIDTH:0]  expected_stress;
   logic                      csr_access;

   // Floor of the square root of the von Mises sum, computed exactly in 64-bit integers.
   function automatic logic [COMPONENT_WIDTH:0] von_mises_root(
      input dim_type                             dim,
      input logic signed [COMPONENT_WIDTH-1:0]   xx, yy, zz, xy, yz, xz
   );
      longint sxx, syy, szz, txy, tyz, txz;
      longint total, root, trial;
      int     k;
      sxx = xx;
      syy = yy;
      szz = zz;
      txy = xy;
      tyz = yz;
      txz = xz;
      total = sxx * sxx + syy * syy - sxx * syy + 3 * txy * txy;
      if (dim == DIM_3D) begin
         total += szz * szz - syy * szz - szz * sxx + 3 * (tyz * tyz + txz * txz);
      end
      root = 0;
      for (k = COMPONENT_WIDTH + 1; k >= 0; k--) begin
         trial = root | (longint'(1) << k);
         if (trial * trial <= total) begin
            root = trial;
         end
      end
      return root[COMPONENT_WIDTH:0];
   endfunction

   assign csr_access = csr_psel && csr_penable && csr_pready
                       && (csr_paddr[2] == CSR_DIMENSION_INDEX);

   // Sample every channel at the clock edge; results are matched in order.
   always @(posedge clock) begin
      if (reset) begin
         dimension_shadow <= DIM_3D;
         expected_stress_q.delete();
         fail_count = 0;
      end else begin
         // Register writes and read-back of the dimension register.
         if (csr_access && csr_pwrite) begin
            dimension_shadow <= csr_pwdata[DIM_WIDTH-1:0];
         end
         if (csr_access && !csr_pwrite) begin
            if (csr_prdata !== CSR_DATA_WIDTH'(dimension_shadow)) begin
               $error("dimension: expected %0d, actual %0d", dimension_shadow, csr_prdata);
               fail_count++;
            end
         end

         // Compare each accepted result with the oldest expected one.
         if (rsp_valid && rsp_ready) begin
            if (expected_stress_q.size() == 0) begin
               $error("equivalent_stress: expected none, actual %0d", rsp_equivalent_stress);
               fail_count++;
            end else begin
               expected_stress = expected_stress_q.pop_front();
               if (rsp_equivalent_stress !== expected_stress) begin
                  $error("equivalent_stress: expected %0d, actual %0d",
                         expected_stress, rsp_equivalent_stress);
                  fail_count++;
               end
            end
         end

         // Each accepted tensor owes exactly one result, queued at the tail.
         if (req_valid && req_ready) begin
            expected_stress_q.insert(expected_stress_q.size(),
               von_mises_root(dimension_shadow,
                  req_normal_xx, req_normal_yy, req_normal_zz,
                  req_shear_xy, req_shear_yz, req_shear_xz));
         end
      end
      outstanding_count = expected_stress_q.size();
   end

endmodule

// ===== test/von_mises_equivalent_stress_unit_tb.sv =====
// Testbench top for the von Mises unit: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps

module von_mises_equivalent_stress_unit_tb;
   import vmes_pkg::*;

   localparam int COMPONENT_WIDTH  = 24;
   localparam int NUM_PHASES       = 6;
   localparam int RANDOM_PER_PHASE = 225;
   localparam int DRAIN_CYCLES     = 40;

   localparam logic signed [COMPONENT_WIDTH-1:0] COMPONENT_MAX =
      {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
   localparam logic signed [COMPONENT_WIDTH-1:0] COMPONENT_MIN =
      {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
   localparam logic signed [COMPONENT_WIDTH-1:0] COMPONENT_ONE = COMPONENT_WIDTH'(1);
   localparam logic signed [COMPONENT_WIDTH-1:0] COMPONENT_NEG_ONE = COMPONENT_WIDTH'(-1);

   // Dimension codes; anything other than the 3D code selects the plane formula.
   localparam dim_type DIM_PLANE = 2'd2;
   localparam dim_type DIM_ALT_0 = 2'd0;
   localparam dim_type DIM_ALT_1 = 2'd1;

   // Byte addresses of the dimension register and of an unused register slot.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_DIMENSION_ADDR = {CSR_DIMENSION_INDEX, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPARE_ADDR     = {~CSR_DIMENSION_INDEX, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [COMPONENT_WIDTH-1:0]   req_normal_xx = '0;
   logic signed [COMPONENT_WIDTH-1:0]   req_normal_yy = '0;
   logic signed [COMPONENT_WIDTH-1:0]   req_normal_zz = '0;
   logic signed [COMPONENT_WIDTH-1:0]   req_shear_xy = '0;
   logic signed [COMPONENT_WIDTH-1:0]   req_shear_yz = '0;
   logic signed [COMPONENT_WIDTH-1:0]   req_shear_xz = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [COMPONENT_WIDTH:0]            rsp_equivalent_stress;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]           csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]           csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]           csr_prdata;
   logic                                csr_pready;

   int fail_count;
   int outstanding_count;
   bit steady_send = 1'b0;

   von_mises_equivalent_stress_unit #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_normal_xx(req_normal_xx),
      .req_normal_yy(req_normal_yy),
      .req_normal_zz(req_normal_zz),
      .req_shear_xy(req_shear_xy),
      .req_shear_yz(req_shear_yz),
      .req_shear_xz(req_shear_xz),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_equivalent_stress(rsp_equivalent_stress),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   vmes_stress_checker #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_normal_xx(req_normal_xx),
      .req_normal_yy(req_normal_yy),
      .req_normal_zz(req_normal_zz),
      .req_shear_xy(req_shear_xy),
      .req_shear_yz(req_shear_yz),
      .req_shear_xz(req_shear_xz),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_equivalent_stress(rsp_equivalent_stress),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .outstanding_count(outstanding_count)
   );

   // Free-running clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #2000000;
      $display("von_mises_equivalent_stress_unit_tb NOT OK");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One stress component: full range mostly, with extremes and small values mixed in.
   function automatic logic signed [COMPONENT_WIDTH-1:0] rand_component();
      int r;
      logic signed [COMPONENT_WIDTH-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = COMPONENT_WIDTH'($urandom);
      end else if (r < 75) begin
         case ($urandom_range(0, 4))
            0: v = COMPONENT_MAX;
            1: v = COMPONENT_MIN;
            2: v = '0;
            3: v = COMPONENT_ONE;
            default: v = COMPONENT_NEG_ONE;
         endcase
      end else begin
         v = COMPONENT_WIDTH'(int'($urandom_range(0, 1023)) - 512);
      end
      return v;
   endfunction

   // Result side: ready in runs of random length, with occasional long open stretches.
   initial begin
      int hold;
      int stall;
      forever begin
         hold = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 400) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (hold) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Offer one tensor, hold it until accepted, then idle for a random gap unless steady_send is set.
   task automatic send_tensor(
      input logic signed [COMPONENT_WIDTH-1:0] xx, yy, zz, xy, yz, xz
   );
      bit taken;
      int gap;
      req_valid     <= 1'b1;
      req_normal_xx <= xx;
      req_normal_yy <= yy;
      req_normal_zz <= zz;
      req_shear_xy  <= xy;
      req_shear_yz  <= yz;
      req_shear_xz  <= xz;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding_count != 0);
      @(posedge clock);
   endtask

   // Register access with a setup phase and an access phase; the checker verifies read data.
   task automatic csr_access(
      input logic                      is_write,
      input logic [CSR_ADDR_WIDTH-1:0] addr,
      input logic [CSR_DATA_WIDTH-1:0] data
   );
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes in phases 1 to 5, read-back in all; extremes and ignored upper bits included.
   task automatic configure_phase(input int phase);
      case (phase)
         1: csr_access(1'b1, CSR_DIMENSION_ADDR, CSR_DATA_WIDTH'(DIM_PLANE));
         2: csr_access(1'b1, CSR_DIMENSION_ADDR, CSR_DATA_WIDTH'(DIM_ALT_0));
         3: begin
            csr_access(1'b1, CSR_DIMENSION_ADDR, CSR_DATA_WIDTH'(DIM_ALT_1));
            // A write to an unused slot must leave the dimension alone.
            csr_access(1'b1, CSR_SPARE_ADDR, CSR_DATA_WIDTH'(DIM_3D));
         end
         4: csr_access(1'b1, CSR_DIMENSION_ADDR, {30'h3FFF_FFFF, DIM_3D});
         5: csr_access(1'b1, CSR_DIMENSION_ADDR, {30'h3FFF_FFFF, DIM_PLANE});
         default: ;
      endcase
      csr_access(1'b0, CSR_DIMENSION_ADDR, '0);
   endtask

   // Hand-picked tensors: field extremes, zero sums, ignored fields in plane mode.
   task automatic directed_tensors(input int phase);
      case (phase)
         0: begin
            send_tensor('0, '0, '0, '0, '0, '0);
            send_tensor(COMPONENT_MAX, COMPONENT_MAX, COMPONENT_MAX,
                        COMPONENT_MAX, COMPONENT_MAX, COMPONENT_MAX);
            send_tensor(COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN,
                        COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN);
            send_tensor(COMPONENT_MAX, COMPONENT_MIN, '0, '0, '0, '0);
            send_tensor('0, '0, '0, COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN);
            send_tensor(COMPONENT_MAX, COMPONENT_MIN, COMPONENT_MIN,
                        COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN);
            // Pure hydrostatic stress has no equivalent stress.
            send_tensor(24'sd1000, 24'sd1000, 24'sd1000, '0, '0, '0);
            send_tensor('0, '0, '0, COMPONENT_ONE, '0, '0);
            send_tensor(COMPONENT_ONE, '0, '0, '0, '0, '0);
            send_tensor(24'h555555, 24'hAAAAAA, 24'h555555,
                        24'hAAAAAA, 24'h555555, 24'hAAAAAA);
            send_tensor(COMPONENT_NEG_ONE, COMPONENT_NEG_ONE, COMPONENT_NEG_ONE,
                        COMPONENT_NEG_ONE, COMPONENT_NEG_ONE, COMPONENT_NEG_ONE);
         end
         1: begin
            // In plane mode zz, yz and xz must have no effect.
            send_tensor(COMPONENT_MAX, COMPONENT_MIN, COMPONENT_MAX,
                        COMPONENT_MIN, COMPONENT_MAX, COMPONENT_MAX);
            send_tensor(24'sd4096, 24'sd4096, COMPONENT_MIN, '0, COMPONENT_MIN, '0);
            send_tensor('0, '0, COMPONENT_MAX, '0, COMPONENT_MIN, COMPONENT_MIN);
            send_tensor(COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN,
                        COMPONENT_MIN, COMPONENT_MIN, COMPONENT_MIN);
         end
         2, 3: begin
            send_tensor(24'hAAAAAA, 24'h555555, COMPONENT_MAX,
                        COMPONENT_MIN, COMPONENT_MAX, COMPONENT_MIN);
         end
         default: ;
      endcase
   endtask

   // Main sequence: reset, then one phase per register setting, then the verdict.
   initial begin
      int phase;
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         configure_phase(phase);
         steady_send = 1'b0;
         directed_tensors(phase);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               steady_send = ($urandom_range(0, 3) == 0);
            end
            // Occasionally let the pipeline run completely dry mid-phase.
            if ($urandom_range(0, 199) == 0) begin
               drain_results();
            end
            send_tensor(rand_component(), rand_component(), rand_component(),
                        rand_component(), rand_component(), rand_component());
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding_count == 0) begin
         $display("von_mises_equivalent_stress_unit_tb OK");
      end else begin
         $display("von_mises_equivalent_stress_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
